@@ design/tlcr_pkg.sv @@
// Shared types, codes and keyword table for the text command line recogniser.
package tlcr_pkg;

   localparam int unsigned NAME_DEPTH = 6;
   localparam int unsigned N_KEYWORDS = 11;
   localparam logic [2:0]  NAME_OVER  = 3'd7;

   typedef logic [NAME_DEPTH-1:0][7:0] name_buf_type;

   typedef enum logic [3:0] {
      CMD_PING    = 4'd0,
      CMD_SET     = 4'd1,
      CMD_GET     = 4'd2,
      CMD_DEL     = 4'd3,
      CMD_EXISTS  = 4'd4,
      CMD_EXPIRE  = 4'd5,
      CMD_INFO    = 4'd6,
      CMD_SIZE    = 4'd7,
      CMD_TTL     = 4'd8,
      CMD_CLEAR   = 4'd9,
      CMD_QUIT    = 4'd10,
      CMD_INVALID = 4'd11
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_EMPTY   = 2'd1,
      ERR_UNKNOWN = 2'd2,
      ERR_ARGS    = 2'd3
   } err_type;

   // Keyword text, first character in the lowest byte, unused bytes zero.
   localparam logic [47:0] KW_TEXT [N_KEYWORDS] = '{
      48'h0000_474E_4950,  // PING
      48'h0000_0054_4553,  // SET
      48'h0000_0054_4547,  // GET
      48'h0000_004C_4544,  // DEL
      48'h5354_5349_5845,  // EXISTS
      48'h4552_4950_5845,  // EXPIRE
      48'h0000_4F46_4E49,  // INFO
      48'h0000_455A_4953,  // SIZE
      48'h0000_004C_5454,  // TTL
      48'h0052_4145_4C43,  // CLEAR
      48'h0000_5449_5551   // QUIT
   };

   localparam logic [2:0] KW_LEN [N_KEYWORDS] = '{
      3'd4, 3'd3, 3'd3, 3'd3, 3'd6, 3'd6, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4
   };

   localparam logic [1:0] KW_NARGS [N_KEYWORDS] = '{
      2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0
   };

   typedef struct packed {
      logic       hit;
      cmd_type    code;
      logic [1:0] nargs;
   } match_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
   endfunction

endpackage

@@ design/text_command_line_recognizer_top.sv @@
// Top level of the text command line recogniser: tokeniser, state and result register.
// Takes one byte per cycle while the result register is empty or being drained and returns
// one result per byte, registered, in the cycle after the transfer; while the receiver keeps
// draining, the sustained rate is one item per clock. Each result carries the
// token index of the byte; the line's last item also carries the command code, error
// code and argument count, and all line state is cleared after it. The token count
// saturates at MAX_TOKENS; reported indexes and argument counts clip at 15.
module text_command_line_recognizer_top #(
   parameter int unsigned MAX_TOKENS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] token_index, [7:4] command, [9:8] error,
                                    // [13:10] arg_count, [15:14] zero
   output logic        rsp_tuser,   // [0] token_char
   output logic        rsp_tlast    // done_res
);

   localparam int unsigned TCW = $clog2(MAX_TOKENS + 1);
   localparam int unsigned XW  = TCW + 4;

   tlcr_pkg::name_buf_type name_buf_ff, name_buf_in;
   logic [2:0]             name_len_ff, name_len_in;
   logic                   in_token_ff, in_token_in;
   logic [TCW-1:0]         tok_cnt_ff, tok_cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   xfer;
   logic                   tok_byte;
   logic [TCW-1:0]         tc_m1;
   logic [XW-1:0]          tc_m1_x;
   logic [3:0]             tc_clip;
   tlcr_pkg::match_type    match;
   tlcr_pkg::cmd_type      cmd;
   tlcr_pkg::err_type      err;
   logic [3:0]             token_index;
   logic [3:0]             arg_count;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign xfer       = req_tvalid && req_tready;
   assign tok_byte   = req_tuser && !tlcr_pkg::is_space(req_tdata);

   // Line state after this byte.
   always_comb begin
      name_buf_in = name_buf_ff;
      name_len_in = name_len_ff;
      in_token_in = in_token_ff;
      tok_cnt_in  = tok_cnt_ff;
      if (req_tuser) begin
         if (!tok_byte) begin
            in_token_in = 1'b0;
         end else begin
            if (!in_token_ff) begin
               in_token_in = 1'b1;
               if (tok_cnt_ff < TCW'(MAX_TOKENS)) begin
                  tok_cnt_in = tok_cnt_ff + 1'b1;
               end
            end
            if (tok_cnt_in == TCW'(1)) begin
               if (name_len_ff < 3'(tlcr_pkg::NAME_DEPTH)) begin
                  for (int i = 0; i < tlcr_pkg::NAME_DEPTH; i++) begin
                     if (name_len_ff == 3'(i)) begin
                        name_buf_in[i] = tlcr_pkg::to_upper(req_tdata);
                     end
                  end
                  name_len_in = name_len_ff + 3'd1;
               end else begin
                  name_len_in = tlcr_pkg::NAME_OVER;
               end
            end
         end
      end
   end

   tlcr_match u_match (
      .name_buf (name_buf_in),
      .name_len (name_len_in),
      .result   (match)
   );

   assign tc_m1   = tok_cnt_in - 1'b1;
   assign tc_m1_x = XW'(tc_m1);
   assign tc_clip = (tc_m1_x > XW'(15)) ? 4'hF : tc_m1_x[3:0];

   always_comb begin
      token_index = tok_byte ? tc_clip : 4'd0;
      cmd         = tlcr_pkg::CMD_PING;
      err         = tlcr_pkg::ERR_NONE;
      arg_count   = 4'd0;
      if (req_tlast) begin
         priority if (tok_cnt_in == '0) begin
            cmd = tlcr_pkg::CMD_INVALID;
            err = tlcr_pkg::ERR_EMPTY;
         end else if (!match.hit) begin
            cmd       = tlcr_pkg::CMD_INVALID;
            err       = tlcr_pkg::ERR_UNKNOWN;
            arg_count = tc_clip;
         end else if (tc_m1 != TCW'(match.nargs)) begin
            cmd       = tlcr_pkg::CMD_INVALID;
            err       = tlcr_pkg::ERR_ARGS;
            arg_count = tc_clip;
         end else begin
            cmd       = match.code;
            arg_count = tc_clip;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (xfer) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, arg_count, err, cmd, token_index};
         rsp_user_in  = tok_byte;
         rsp_last_in  = req_tlast;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_buf_ff  <= '0;
         name_len_ff  <= 3'd0;
         in_token_ff  <= 1'b0;
         tok_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (xfer) begin
            if (req_tlast) begin
               name_buf_ff <= '0;
               name_len_ff <= 3'd0;
               in_token_ff <= 1'b0;
               tok_cnt_ff  <= '0;
            end else begin
               name_buf_ff <= name_buf_in;
               name_len_ff <= name_len_in;
               in_token_ff <= in_token_in;
               tok_cnt_ff  <= tok_cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ design/tlcr_match.sv @@
// Parallel compare of the command name against the keyword table.
module tlcr_match (
   input  tlcr_pkg::name_buf_type name_buf,
   input  logic [2:0]             name_len,
   output tlcr_pkg::match_type    result
);

   // Bytes past the name length are always zero, so a full compare suffices.
   always_comb begin
      result.hit   = 1'b0;
      result.code  = tlcr_pkg::CMD_INVALID;
      result.nargs = 2'd0;
      for (int k = tlcr_pkg::N_KEYWORDS - 1; k >= 0; k--) begin
         if ((tlcr_pkg::KW_LEN[k] == name_len) &&
             (tlcr_pkg::KW_TEXT[k] == 48'(name_buf))) begin
            result.hit   = 1'b1;
            result.code  = tlcr_pkg::cmd_type'(4'(k));
            result.nargs = tlcr_pkg::KW_NARGS[k];
         end
      end
   end

endmodule

@@ bench/text_command_line_recognizer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the command line recogniser: follows both channels, predicts every result and compares.
module text_command_line_recognizer_checker #(
   parameter int unsigned MAX_TOKENS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int unsigned mismatches,
   output int unsigned outstanding
);

   typedef struct {
      logic [3:0]        index;
      logic              in_word;
      logic              line_end;
      tlcr_pkg::cmd_type code;
      tlcr_pkg::err_type fault;
      logic [3:0]        args;
   } byte_result_type;

   // line state, cleared after every line end
   logic [7:0]  name_bytes [tlcr_pkg::NAME_DEPTH];
   logic [2:0]  name_len;
   logic        inside_word;
   int unsigned word_count;

   byte_result_type byte_results_q [$];

   function automatic string keyword_text(input int k);
      case (k)
         0:       return "PING";
         1:       return "SET";
         2:       return "GET";
         3:       return "DEL";
         4:       return "EXISTS";
         5:       return "EXPIRE";
         6:       return "INFO";
         7:       return "SIZE";
         8:       return "TTL";
         9:       return "CLEAR";
         default: return "QUIT";
      endcase
   endfunction

   function automatic int unsigned keyword_args(input int k);
      case (k)
         1, 5:          return 2;
         2, 3, 4, 8:    return 1;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [3:0] clip15(input int unsigned v);
      return (v > 15) ? 4'd15 : v[3:0];
   endfunction

   task automatic clear_line();
      int i;
      for (i = 0; i < tlcr_pkg::NAME_DEPTH; i++) name_bytes[i] = 8'h00;
      name_len    = 3'd0;
      inside_word = 1'b0;
      word_count  = 0;
   endtask

   task automatic tokenise_byte(input logic [7:0] ch, input logic has, input logic fin,
                                output byte_result_type r);
      logic [7:0]  up;
      int          k;
      int          i;
      int          hit;
      bit          same;
      string       kw;
      r.index    = 4'd0;
      r.in_word  = 1'b0;
      r.line_end = 1'b0;
      r.code     = tlcr_pkg::CMD_PING;
      r.fault    = tlcr_pkg::ERR_NONE;
      r.args     = 4'd0;
      if (has) begin
         if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) begin
            inside_word = 1'b0;
         end else begin
            if (!inside_word) begin
               inside_word = 1'b1;
               if (word_count < MAX_TOKENS) word_count++;
            end
            if (word_count == 1) begin
               if (name_len < tlcr_pkg::NAME_DEPTH) begin
                  up = ch;
                  if (ch >= 8'h61 && ch <= 8'h7A) up = ch - 8'h20;  // a-z only
                  name_bytes[name_len] = up;
                  name_len++;
               end else begin
                  name_len = tlcr_pkg::NAME_OVER;
               end
            end
            r.in_word = 1'b1;
            r.index   = clip15(word_count - 1);
         end
      end
      if (fin) begin
         r.line_end = 1'b1;
         if (word_count == 0) begin
            r.code  = tlcr_pkg::CMD_INVALID;
            r.fault = tlcr_pkg::ERR_EMPTY;
         end else begin
            r.args = clip15(word_count - 1);
            hit = tlcr_pkg::N_KEYWORDS;
            for (k = 0; k < tlcr_pkg::N_KEYWORDS; k++) begin
               kw = keyword_text(k);
               if (hit == tlcr_pkg::N_KEYWORDS && kw.len() == name_len) begin
                  same = 1'b1;
                  for (i = 0; i < kw.len(); i++)
                     if (kw[i] != name_bytes[i]) same = 1'b0;
                  if (same) hit = k;
               end
            end
            if (hit == tlcr_pkg::N_KEYWORDS) begin
               r.code  = tlcr_pkg::CMD_INVALID;
               r.fault = tlcr_pkg::ERR_UNKNOWN;
            end else if (word_count - 1 != keyword_args(hit)) begin
               r.code  = tlcr_pkg::CMD_INVALID;
               r.fault = tlcr_pkg::ERR_ARGS;
            end else begin
               r.code  = tlcr_pkg::cmd_type'(hit);
               r.fault = tlcr_pkg::ERR_NONE;
            end
         end
         clear_line();
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      byte_result_type want;
      if (reset) begin
         clear_line();
         byte_results_q.delete();
      end else begin
         // pop before append: a result never belongs to the transfer of the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (byte_results_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual data %h user %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = byte_results_q.pop_front();
               check_field("token_index", want.index, rsp_tdata[3:0]);
               check_field("token_char", want.in_word, rsp_tuser);
               check_field("done_res", want.line_end, rsp_tlast);
               check_field("command", int'(want.code), rsp_tdata[7:4]);
               check_field("error", int'(want.fault), rsp_tdata[9:8]);
               check_field("arg_count", want.args, rsp_tdata[13:10]);
            end
         end
         if (req_tvalid && req_tready) begin
            tokenise_byte(req_tdata, req_tuser, req_tlast, want);
            byte_results_q.insert(byte_results_q.size(), want);
         end
      end
      outstanding <= byte_results_q.size();
   end

endmodule

@@ bench/text_command_line_recognizer_top_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the command line recogniser: clock, reset, line stimulus, receiver and verdict.
module text_command_line_recognizer_top_test;

   localparam int unsigned LINE_ITEMS  = 1550;
   localparam int unsigned HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned items_sent;
   bit          steady;
   bit          hold_asked;
   logic [7:0]  line_bytes [$];

   text_command_line_recognizer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   text_command_line_recognizer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[text_command_line_recognizer_top] ERROR");
      $finish;
   end

   function automatic string command_word(input int k);
      case (k)
         0:       return "PING";
         1:       return "SET";
         2:       return "GET";
         3:       return "DEL";
         4:       return "EXISTS";
         5:       return "EXPIRE";
         6:       return "INFO";
         7:       return "SIZE";
         8:       return "TTL";
         9:       return "CLEAR";
         default: return "QUIT";
      endcase
   endfunction

   function automatic int command_args(input int k);
      case (k)
         1, 5:       return 2;
         2, 3, 4, 8: return 1;
         default:    return 0;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] space_byte();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? 8'h20 : 8'(8'h09 + r);
   endfunction

   // any byte that is not whitespace, letters favoured
   function automatic logic [7:0] word_byte();
      int b;
      if ($urandom_range(0, 1)) begin
         b = $urandom_range(8'h41, 8'h5A);
         if ($urandom_range(0, 1)) b += 8'h20;
      end else begin
         b = $urandom_range(0, 249);
         if (b >= 8'h09) b += 5;
         if (b >= 8'h20) b += 1;
      end
      return 8'(b);
   endfunction

   task automatic add_spaces(input int n);
      int i;
      for (i = 0; i < n; i++) line_bytes.insert(line_bytes.size(), space_byte());
   endtask

   task automatic add_word(input int n);
      int i;
      for (i = 0; i < n; i++) line_bytes.insert(line_bytes.size(), word_byte());
   endtask

   task automatic put_byte(input logic [7:0] ch, input logic has, input logic fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= has;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (has || fin) items_sent++;
   endtask

   task automatic send_line(input bit bare_end, input bit noisy);
      int i;
      for (i = 0; i < line_bytes.size(); i++) begin
         if (noisy && $urandom_range(0, 19) == 0) put_byte(8'($urandom), 1'b0, 1'b0);
         put_byte(line_bytes[i], 1'b1, !bare_end && (i == line_bytes.size() - 1));
      end
      if (bare_end || line_bytes.size() == 0) put_byte(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // mostly keyword lines with random case and argument counts, the rest raw noise
   task automatic compose_line();
      int    r;
      int    k;
      int    i;
      int    n;
      int    wanted;
      string kw;
      logic [7:0] c;
      line_bytes.delete();
      if ($urandom_range(0, 99) < 75) begin
         if ($urandom_range(0, 4) == 0) add_spaces($urandom_range(1, 2));
         k  = $urandom_range(0, tlcr_pkg::N_KEYWORDS - 1);
         kw = command_word(k);
         r  = $urandom_range(0, 99);
         if (r < 90) begin
            n = (r >= 75 && r < 82) ? kw.len() - 1 : kw.len();
            for (i = 0; i < n; i++) begin
               c = kw[i];
               if ($urandom_range(0, 1)) c = c | 8'h20;
               line_bytes.insert(line_bytes.size(), c);
            end
            if (r >= 82) line_bytes.insert(line_bytes.size(), word_byte());
         end else begin
            add_word($urandom_range(1, 9));
         end
         r = $urandom_range(0, 99);
         if (r < 60)      wanted = command_args(k);
         else if (r < 85) wanted = $urandom_range(0, 3);
         else if (r < 95) wanted = $urandom_range(4, 8);
         else             wanted = $urandom_range(13, 20);  // near and past the token count limit
         for (i = 0; i < wanted; i++) begin
            add_spaces($urandom_range(1, 3));
            add_word($urandom_range(1, 5));
         end
         if ($urandom_range(0, 4) == 0) add_spaces($urandom_range(1, 2));
      end else begin
         n = $urandom_range(0, 12);
         for (i = 0; i < n; i++)
            line_bytes.insert(line_bytes.size(),
                              ($urandom_range(0, 2) == 0) ? space_byte()
                                                          : 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : receiver
      int r;
      bit hold_served;
      hold_served = 1'b0;
      rsp_tready  = 1'b0;
      forever begin
         if (hold_asked && !hold_served) begin
            // long hold-off while the sender keeps offering bytes
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else if (steady) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end else if (r < 92) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(5, 30)) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      bit paused;
      paused     = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      steady     = 1'b0;
      hold_asked = 1'b0;
      items_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty line ended by a bare line end
      line_bytes.delete();
      send_line(1'b1, 1'b0);
      // whitespace only, the line end on a whitespace byte
      line_bytes = '{8'h20, 8'h0D, 8'h09};
      send_line(1'b0, 1'b0);
      // mixed-case keyword, verdict on its last letter
      line_bytes = '{8'h70, 8'h49, 8'h6E, 8'h47};
      send_line(1'b0, 1'b0);
      // SET with a NUL argument and a 0xFF argument, ignored bytes in between
      line_bytes = '{8'h53, 8'h65, 8'h54, 8'h0B, 8'h00, 8'h0C, 8'h0A, 8'hFF};
      send_line(1'b0, 1'b1);
      // name longer than six bytes
      line_bytes = '{8'h45, 8'h58, 8'h50, 8'h49, 8'h52, 8'h45, 8'h53};
      send_line(1'b1, 1'b0);
      wait_drained();

      while (items_sent < LINE_ITEMS) begin
         if (!paused && items_sent >= 400) begin
            wait_drained();
            paused = 1'b1;
         end
         if (items_sent >= 700) hold_asked = 1'b1;
         steady = ($urandom_range(0, 4) == 0);
         compose_line();
         send_line($urandom_range(0, 1), 1'b1);
      end
      steady = 1'b0;
      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("[text_command_line_recognizer_top] OK");
      end else begin
         $display("[text_command_line_recognizer_top] ERROR");
      end
      $finish;
   end

endmodule
